/* rtl/charset_html_escape_assert.svh */
// ----------------------------------------------------------------------------
// charset_html_escape assertion macros
// shared property forms for the html escaper checks
// ----------------------------------------------------------------------------
`ifndef CHARSET_HTML_ESCAPE_ASSERT_SVH
`define CHARSET_HTML_ESCAPE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CHE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("charset_html_escape check failed");

// next-cycle implication, disabled in reset
`define CHE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("charset_html_escape check failed");

`endif

/* rtl/che_pkg.sv */
// ----------------------------------------------------------------------------
// che_pkg
// types, constants and the charset table of the html escaper
// ----------------------------------------------------------------------------
package che_pkg;

	localparam int CAPACITY_BITS = 16;
	localparam int CFG_W         = 16;
	localparam int BYTE_W        = 8;
	localparam int BUDGET_W      = 17;
	localparam int MAX_OUT       = 5;
	localparam int CNT_W         = 3;
	localparam int BUDGET_MARGIN = 6;

	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(1024);
	localparam logic [CFG_W-1:0] CAP_MASK  = CFG_W'((64'd1 << CAPACITY_BITS) - 64'd1);

	typedef logic [BYTE_W-1:0]          byte_t;
	typedef logic [CFG_W-1:0]           cap_t;
	typedef logic signed [BUDGET_W-1:0] budget_t;
	typedef logic [CNT_W-1:0]           cnt_t;

	localparam byte_t CH_NUL = 8'h00;
	localparam byte_t CH_LT  = 8'h3C;
	localparam byte_t CH_GT  = 8'h3E;
	localparam byte_t CH_AMP = 8'h26;
	localparam byte_t CH_NL  = 8'h0A;

	// escape burst: bytes[0] leaves first
	typedef struct packed {
		byte_t [MAX_OUT-1:0] bytes;
		cnt_t                cnt;
		logic                last;
	} burst_t;

	// per-string tracking state
	typedef struct packed {
		budget_t budget;
		logic    closed;
	} track_t;

	localparam byte_t CHARSET_MAP [256] = '{
		8'h00, 8'h23, 8'h23, 8'h23, 8'h23, 8'h2E, 8'h23, 8'h23,
		8'h23, 8'h09, 8'h0A, 8'h23, 8'h20, 8'h0D, 8'h2E, 8'h2E,
		8'h5B, 8'h5D, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
		8'h36, 8'h37, 8'h38, 8'h39, 8'h2E, 8'h3C, 8'h3D, 8'h3E,
		8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
		8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
		8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
		8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F,
		8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
		8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
		8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
		8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
		8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
		8'h78, 8'h79, 8'h7A, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h3C,
		8'h3C, 8'h3D, 8'h3E, 8'h23, 8'h23, 8'h2E, 8'h23, 8'h23,
		8'h23, 8'h23, 8'h20, 8'h23, 8'h20, 8'h3E, 8'h2E, 8'h2E,
		8'h5B, 8'h5D, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
		8'h36, 8'h37, 8'h38, 8'h39, 8'h2E, 8'h3C, 8'h3D, 8'h3E,
		8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
		8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
		8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
		8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F,
		8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
		8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
		8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
		8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
		8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
		8'h78, 8'h79, 8'h7A, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h3C
	};

	// budget reload: capacity minus the reserved margin
	function automatic budget_t rearm_budget(input cap_t cap);
		budget_t b;
		b = budget_t'({1'b0, cap & CAP_MASK}) - budget_t'(BUDGET_MARGIN);
		return b;
	endfunction

endpackage

/* rtl/che_if.sv */
// ----------------------------------------------------------------------------
// che interfaces
// valid/ready channels of the html escaper
// ----------------------------------------------------------------------------
interface che_in_if;
	import che_pkg::*;
	logic  valid;
	logic  ready;
	byte_t char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface che_out_if;
	import che_pkg::*;
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface che_cfg_if;
	import che_pkg::*;
	logic valid;
	logic ready;
	cap_t output_capacity;

	modport source (output valid, output output_capacity, input ready);
	modport sink   (input valid, input output_capacity, output ready);
endinterface

/* rtl/che_expand.sv */
// ----------------------------------------------------------------------------
// che_expand
// maps one source code and builds its escape burst and next string state
// ----------------------------------------------------------------------------
module che_expand (
	input  che_pkg::byte_t  char_code,
	input  che_pkg::cap_t   cap,
	input  che_pkg::track_t cur,
	output che_pkg::burst_t burst,
	output che_pkg::track_t nxt
);
	import che_pkg::*;

	byte_t ch;
	byte_t [MAX_OUT-1:0] esc;
	cnt_t  n;

	// escape text for the mapped character
	always_comb begin
		ch  = CHARSET_MAP[char_code];
		esc = '0;
		n   = cnt_t'(1);
		case (ch)
			CH_LT: begin
				esc[0] = 8'h26; esc[1] = 8'h6C; esc[2] = 8'h74; esc[3] = 8'h3B;
				n = cnt_t'(4);
			end
			CH_GT: begin
				esc[0] = 8'h26; esc[1] = 8'h67; esc[2] = 8'h74; esc[3] = 8'h3B;
				n = cnt_t'(4);
			end
			CH_NL: begin
				esc[0] = 8'h3C; esc[1] = 8'h62; esc[2] = 8'h72; esc[3] = 8'h2F;
				esc[4] = 8'h3E;
				n = cnt_t'(5);
			end
			CH_AMP: begin
				esc[0] = 8'h26; esc[1] = 8'h61; esc[2] = 8'h6D; esc[3] = 8'h70;
				esc[4] = 8'h3B;
				n = cnt_t'(5);
			end
			default: begin
				esc[0] = ch;
			end
		endcase
	end

	// string control: terminator, drop, budget close, or escape
	always_comb begin
		burst       = '0;
		burst.bytes = '0;
		nxt         = cur;
		if (char_code == CH_NUL) begin
			nxt.budget = rearm_budget(cap);
			nxt.closed = 1'b0;
			if (!cur.closed) begin
				burst.cnt  = cnt_t'(1);
				burst.last = 1'b1;
			end
		end else if (cur.closed) begin
			burst.cnt = '0;
		end else if (cur.budget <= budget_t'(0)) begin
			nxt.closed = 1'b1;
			burst.cnt  = cnt_t'(1);
			burst.last = 1'b1;
		end else begin
			burst.bytes = esc;
			burst.cnt   = n;
			nxt.budget  = cur.budget - budget_t'({1'b0, n});
		end
	end

endmodule

/* rtl/charset_html_escape.sv */
// ----------------------------------------------------------------------------
// charset_html_escape
// charset-mapping html escaper with a per-string output budget
// ----------------------------------------------------------------------------
// path: src word -> burst stage -> output register -> dst
// throughput: one result word per cycle while dst is ready; a source word
//   that expands to n result words (n = 1, 4 or 5) holds src until its last
//   byte leaves the single output byte register; dropped words give nothing
// reset: capacity 1024, budget 1018, string open, both stages empty;
//   cfg is always ready and a write reloads the budget and reopens the string
// ----------------------------------------------------------------------------
module charset_html_escape (
	input  logic             clk,
	input  logic             arst_n,
	che_in_if.sink           src,
	che_out_if.source        dst,
	che_cfg_if.sink          cfg
);
	import che_pkg::*;

	`include "charset_html_escape_assert.svh"

	// configuration and per-string state
	cap_t   cap_q;
	track_t track_q;

	// burst stage: remaining escape bytes, head in slot 0
	byte_t [MAX_OUT-1:0] bytes_s1;
	cnt_t                cnt_s1;
	logic                last_s1;

	// output register
	logic  out_valid_q;
	byte_t out_byte_q;
	logic  out_last_q;

	// combinational results of the expander
	burst_t burst;
	track_t track_nxt;

	logic out_take;
	logic burst_move;
	logic src_acc;
	logic cfg_acc;

	che_expand u_expand (
		.char_code (src.char_code),
		.cap       (cap_q),
		.cur       (track_q),
		.burst     (burst),
		.nxt       (track_nxt)
	);

	// output register can load when empty or being drained
	assign out_take   = !out_valid_q || dst.ready;
	assign burst_move = (cnt_s1 != '0) && out_take;

	// take a new word once the burst stage empties, even in the same cycle
	assign src.ready = (cnt_s1 == '0) || ((cnt_s1 == cnt_t'(1)) && out_take);
	assign src_acc   = src.valid && src.ready;

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid;

	assign dst.valid    = out_valid_q;
	assign dst.out_byte = out_byte_q;
	assign dst.last     = out_last_q;

	// capacity register and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q          <= CAP_RESET;
			track_q.budget <= rearm_budget(CAP_RESET);
			track_q.closed <= 1'b0;
		end else if (cfg_acc) begin
			// writes should only land while idle; the block itself does not enforce it
			cap_q          <= cfg.output_capacity;
			track_q.budget <= rearm_budget(cfg.output_capacity);
			track_q.closed <= 1'b0;
		end else if (src_acc) begin
			track_q <= track_nxt;
		end
	end

	// burst stage count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
		end else if (src_acc && (burst.cnt != '0)) begin
			cnt_s1 <= burst.cnt;
		end else if (burst_move) begin
			cnt_s1 <= cnt_s1 - cnt_t'(1);
		end
	end

	// burst stage payload, shifted toward slot 0 as bytes leave
	always_ff @(posedge clk) begin
		if (src_acc && (burst.cnt != '0)) begin
			bytes_s1 <= burst.bytes;
			last_s1  <= burst.last;
		end else if (burst_move) begin
			bytes_s1 <= {byte_t'(0), bytes_s1[MAX_OUT-1:1]};
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= (cnt_s1 != '0);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (burst_move) begin
			out_byte_q <= bytes_s1[0];
			out_last_q <= last_s1 && (cnt_s1 == cnt_t'(1));
		end
	end

	// the terminator is always a zero byte
	`CHE_ASSERT_IMP(a_last_is_zero, dst.valid && dst.last, dst.out_byte == CH_NUL)

	// escapes overshoot by at most four below zero, reload floor is minus six
	`CHE_ASSERT_IMP(a_budget_floor, 1'b1, track_q.budget >= -budget_t'(BUDGET_MARGIN))

	// a closed string stays closed until a zero word or a config write
	`CHE_ASSERT_NXT(a_closed_holds,
		track_q.closed && !cfg_acc && !(src_acc && (src.char_code == CH_NUL)),
		track_q.closed)

	// a closed string never loads a burst from a nonzero word
	`CHE_ASSERT_NXT(a_closed_drops,
		track_q.closed && !cfg_acc && src_acc && (src.char_code != CH_NUL)
			&& (cnt_s1 == '0),
		cnt_s1 == '0)

endmodule

/* bench/che_html_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// che_html_checker
// watches the escaper channels, predicts the html words that each source word
// gives and compares them in order with the words leaving dst
// ----------------------------------------------------------------------------
module che_html_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	input  logic           src_ready,
	input  che_pkg::byte_t char_code,
	input  logic           dst_valid,
	input  logic           dst_ready,
	input  che_pkg::byte_t out_byte,
	input  logic           last,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  che_pkg::cap_t  output_capacity,
	output int unsigned    mismatch_count,
	output int unsigned    words_pending
);
	import che_pkg::*;

	localparam byte_t NUL = 8'h00;
	localparam byte_t LT  = "<";
	localparam byte_t GT  = ">";
	localparam byte_t AMP = "&";
	localparam byte_t NL  = 8'h0A;

	typedef struct packed {
		byte_t data;
		logic  last;
	} html_word_t;

	html_word_t  html_pending[$];
	cap_t        capacity;
	budget_t     budget;
	logic        closed;
	int unsigned fail_total = 0;

	// game charset to ascii
	function automatic byte_t game_to_ascii(input byte_t code);
		logic [6:0] c;
		c = code[6:0];
		if (c == 7'd127) return LT;
		if (c >= 7'd32) return byte_t'(c);
		if (c >= 7'd18 && c <= 7'd27) return byte_t'(c) + 8'd30;
		case (c)
			7'd16: return "[";
			7'd17: return "]";
			7'd14, 7'd15, 7'd28: return ".";
			7'd29: return LT;
			7'd30: return "=";
			7'd31: return GT;
			default: ;
		endcase
		// control row differs between the two halves
		if (!code[7]) begin
			case (c)
				7'd0: return NUL;
				7'd5: return ".";
				7'd9: return 8'h09;
				7'd10: return NL;
				7'd12: return " ";
				7'd13: return 8'h0D;
				default: return "#";
			endcase
		end else begin
			case (c)
				7'd0: return LT;
				7'd1: return "=";
				7'd2, 7'd13: return GT;
				7'd5: return ".";
				7'd10, 7'd12: return " ";
				default: return "#";
			endcase
		end
	endfunction

	function automatic void reload_budget();
		budget = budget_t'({1'b0, capacity & CAP_MASK}) - budget_t'(BUDGET_MARGIN);
		closed = 1'b0;
	endfunction

	function automatic void push_html(input byte_t b, input logic l);
		html_word_t w;
		w.data = b;
		w.last = l;
		html_pending.push_back(w);
	endfunction

	function automatic void predict_html(input byte_t code);
		byte_t ch;
		string seq;
		logic  was_closed;
		if (code == NUL) begin
			was_closed = closed;
			reload_budget();
			// a string cut off by the budget already has its terminator
			if (!was_closed) push_html(NUL, 1'b1);
		end else if (closed) begin
			// dropped
		end else if (budget <= 0) begin
			closed = 1'b1;
			push_html(NUL, 1'b1);
		end else begin
			ch = game_to_ascii(code);
			case (ch)
				LT: seq = "&lt;";
				GT: seq = "&gt;";
				NL: seq = "<br/>";
				AMP: seq = "&amp;";
				default: seq = "";
			endcase
			if (seq.len() == 0) begin
				push_html(ch, 1'b0);
				budget = budget - budget_t'(1);
			end else begin
				for (int i = 0; i < seq.len(); i++) push_html(byte_t'(seq[i]), 1'b0);
				budget = budget - budget_t'(seq.len());
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		html_word_t exp_word;
		if (!arst_n) begin
			html_pending.delete();
			capacity = 16'd1024;
			reload_budget();
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity = output_capacity;
				reload_budget();
			end
			if (src_valid && src_ready) predict_html(char_code);
			if (dst_valid && dst_ready) begin
				if (html_pending.size() == 0) begin
					$error("unexpected word: out_byte 8'h%02h, last %0b", out_byte, last);
					fail_total++;
				end else begin
					exp_word = html_pending.pop_front();
					if (out_byte !== exp_word.data) begin
						$error("out_byte mismatch: expected 8'h%02h, actual 8'h%02h",
							exp_word.data, out_byte);
						fail_total++;
					end
					if (last !== exp_word.last) begin
						$error("last mismatch: expected %0b, actual %0b", exp_word.last, last);
						fail_total++;
					end
				end
			end
		end
		words_pending  <= html_pending.size();
		mismatch_count <= fail_total;
	end

endmodule

/* bench/charset_html_escape_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charset_html_escape_test
// drives strings of game-charset bytes into the html escaper under several
// output capacities and idle patterns; the checker predicts every html word
// ----------------------------------------------------------------------------
module charset_html_escape_test;
	import che_pkg::*;

	// generous: every word expanding to five, each waiting out long stalls
	localparam int TIMEOUT_CYCLES  = 400000;
	localparam int ITEMS_PER_PHASE = 75;
	// spare cycles after the last result before the next write
	localparam int SETTLE_CYCLES   = 8;

	// source codes whose mapped character is escaped, plus the terminator
	localparam byte_t GC_NUL    = 8'h00;
	localparam byte_t GC_LT     = 8'd60;
	localparam byte_t GC_GT     = 8'd62;
	localparam byte_t GC_AMP    = 8'd38;
	localparam byte_t GC_NL     = 8'd10;
	localparam byte_t GC_HI_LT  = 8'd128;
	localparam byte_t GC_HI_AMP = 8'd166;
	localparam byte_t GC_DEL    = 8'd127;

	logic        clk;
	logic        arst_n;
	int          send_idle_pct;
	int          recv_idle_pct;
	int unsigned cycle_count = 0;
	int unsigned mismatches;
	int unsigned words_pending;

	che_in_if  in_ch ();
	che_out_if out_ch ();
	che_cfg_if cfg_ch ();

	charset_html_escape u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (in_ch),
		.dst    (out_ch),
		.cfg    (cfg_ch)
	);

	che_html_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.src_valid       (in_ch.valid),
		.src_ready       (in_ch.ready),
		.char_code       (in_ch.char_code),
		.dst_valid       (out_ch.valid),
		.dst_ready       (out_ch.ready),
		.out_byte        (out_ch.out_byte),
		.last            (out_ch.last),
		.cfg_valid       (cfg_ch.valid),
		.cfg_ready       (cfg_ch.ready),
		.output_capacity (cfg_ch.output_capacity),
		.mismatch_count  (mismatches),
		.words_pending   (words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stalls at the current rate, a fresh roll every cycle
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one source word; valid stays up across back-to-back words
	task automatic send_word(input byte_t code);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.char_code <= code;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// hold the sender until every predicted word has left, then let it settle
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_capacity(input cap_t cap);
		cfg_ch.valid           <= 1'b1;
		cfg_ch.output_capacity <= cap;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly small capacities so the budget runs out inside a string
	function automatic cap_t pick_capacity();
		case ($urandom_range(9))
			0: return cap_t'(7);
			1: return cap_t'(16'hFFFF);
			2: return cap_t'($urandom_range(16'hFFFF));
			3: return cap_t'(1024);
			4: return cap_t'($urandom_range(6));
			default: return cap_t'($urandom_range(7, 48));
		endcase
	endfunction

	// random nonzero byte, biased toward the escaped characters
	function automatic byte_t pick_code();
		if ($urandom_range(3) != 0) return byte_t'($urandom_range(1, 255));
		case ($urandom_range(9))
			0: return GC_LT;
			1: return GC_GT;
			2: return GC_AMP;
			3: return GC_NL;
			4: return GC_HI_LT;
			5: return GC_HI_AMP;
			6: return GC_DEL;
			7: return 8'd29;
			8: return 8'd141;
			default: return 8'd255;
		endcase
	endfunction

	// a string of random content, usually closed by a zero
	task automatic send_string(inout int items_sent);
		int len;
		len = $urandom_range(1, 30);
		for (int i = 0; i < len; i++) send_word(pick_code());
		items_sent += len;
		// now and then leave it open: the next write or zero must cope
		if ($urandom_range(9) != 0) begin
			send_word(GC_NUL);
			items_sent++;
		end
	endtask

	task automatic run_directed();
		// default capacity: every escape, both halves of the table, end
		send_word("A");
		send_word(8'h01);
		send_word(8'hFF);
		send_word(GC_LT);
		send_word(GC_GT);
		send_word(GC_AMP);
		send_word(GC_NL);
		send_word(GC_HI_LT);
		send_word(GC_HI_AMP);
		send_word(GC_DEL);
		send_word(GC_NUL);
		// smallest legal budget: one byte, then the string closes,
		// later bytes drop and a zero rearms without a result
		drain_results();
		write_capacity(cap_t'(7));
		send_word("A");
		send_word("B");
		send_word("C");
		send_word(GC_NUL);
		// escape written whole past the budget
		send_word(GC_LT);
		send_word("D");
		send_word(GC_NUL);
		// deepest overshoot: a five-byte break with one byte left
		drain_results();
		write_capacity(cap_t'(8));
		send_word("A");
		send_word(GC_NL);
		send_word("B");
		// zero capacity; the write also reopens the closed string
		drain_results();
		write_capacity(cap_t'(0));
		send_word(GC_NUL);
		send_word("x");
		send_word(GC_NUL);
		// all ones capacity
		drain_results();
		write_capacity(cap_t'(16'hFFFF));
		send_word("A");
		send_word(GC_NUL);
	endtask

	initial begin
		int items_sent;
		arst_n                 = 1'b0;
		in_ch.valid            = 1'b0;
		in_ch.char_code        = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.output_capacity = '0;
		send_idle_pct          = 38;
		recv_idle_pct          = 47;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// three idle patterns: receiver-heavy, sender-heavy gaps, none
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 47 : 0;
			recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 38 : 0;
			items_sent = 0;
			while (items_sent < ITEMS_PER_PHASE) begin
				// a new capacity needs the block idle
				if ($urandom_range(3) == 0) begin
					drain_results();
					write_capacity(pick_capacity());
				end
				send_string(items_sent);
			end
		end

		// wait for the tail, then give the pipe time to show strays
		drain_results();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && words_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
